// File: src/kth_largest_stream_select_defines.svh
// Assertion macros used by the top-level RTL file.
// Each macro expects clk and arst_n in scope.
`ifndef KTH_LARGEST_STREAM_SELECT_DEFINES_SVH
`define KTH_LARGEST_STREAM_SELECT_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define KSEL_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// A condition that must hold in the cycle after the antecedent.
`define KSEL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define KSEL_ASSERT_ALWAYS(label, expr)
`define KSEL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: src/ksel_pkg.sv
package ksel_pkg;

	// Width of the rank register.
	localparam int unsigned RANK_W = 5;

	// Per-cycle control handed from the chain controller to each cell.
	typedef struct packed {
		logic valid;  // The cell holds one of the kept values.
		logic load;   // The cell takes part in this cycle's insertion.
	} cell_ctl_t;

endpackage

// File: src/kth_largest_stream_select.sv
// The item with tlast leaves a pending result that moves to the output register once it is free.
// Throughput: one item per cycle while s_tready is high; the compare-and-shift cells insert each.
// Input is held off only while a finished result waits behind an output item not yet taken.
// Reset (arst_n low, asynchronous): kept count cleared, rank_k set to 1, no output item pending.
// Kept values have no reset; only entries below the kept count are ever read.
`include "kth_largest_stream_select_defines.svh"

module kth_largest_stream_select
	import ksel_pkg::*;
#(
	parameter int unsigned K_MAX      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration: rank_k.
	input  logic                                 cfg_we,
	input  logic [RANK_W-1:0]                    cfg_wdata,
	// Input items.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]      s_tdata,  // [DATA_WIDTH-1:0] sample_value
	input  logic                                 s_tlast,  // set_end
	// Result items.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_tdata,  // [DATA_WIDTH-1:0] kth_value
	output logic                                 m_tuser   // found
);

	localparam int unsigned TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int unsigned CNT_W   = $clog2(K_MAX + 1);
	localparam int unsigned IDX_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
	localparam int unsigned KW      = (CNT_W > RANK_W) ? CNT_W : RANK_W;

	logic [RANK_W-1:0]            rank_q;
	logic [CNT_W-1:0]             count_q;
	logic                         pend_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic                         found_s1;
	logic                         m_tvalid_q;
	logic [DATA_WIDTH-1:0]        m_data_q;
	logic                         m_found_q;

	logic [RANK_W-1:0]            rank_nz;
	logic [KW-1:0]                rank_w;
	logic [CNT_W-1:0]             k_eff;
	logic                         s_acc;
	logic                         can_load;
	logic                         grow;
	logic                         replace;
	logic                         min_gt;
	logic [IDX_W-1:0]             last_idx;
	logic [CNT_W-1:0]             new_count;
	logic signed [DATA_WIDTH-1:0] sample;

	cell_ctl_t                    ctl       [K_MAX];
	logic signed [DATA_WIDTH-1:0] cell_val  [K_MAX];
	logic signed [DATA_WIDTH-1:0] left_val  [K_MAX];
	logic                         left_gt   [K_MAX];
	logic [K_MAX-1:0]             gt_vec;

	// Rank register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_W'(1);
		end else if (cfg_we) begin
			rank_q <= cfg_wdata;
		end
	end

	// Effective k: zero counts as one, and k saturates at the chain length.
	always_comb begin
		rank_nz = (rank_q == '0) ? RANK_W'(1) : rank_q;
		rank_w  = KW'(rank_nz);
		if (rank_w > KW'(K_MAX)) begin
			k_eff = CNT_W'(K_MAX);
		end else begin
			k_eff = CNT_W'(rank_w);
		end
	end

	// Handshake: input waits only while a pending result cannot move out.
	assign can_load = !m_tvalid_q || m_tready;
	assign s_tready = !pend_s1 || can_load;
	assign s_acc    = s_tvalid && s_tready;
	assign sample   = $signed(s_tdata[DATA_WIDTH-1:0]);

	// Decide between growing the kept list and replacing its smallest entry.
	always_comb begin
		last_idx  = IDX_W'(count_q - CNT_W'(1));
		min_gt    = gt_vec[last_idx];
		grow      = (count_q < k_eff);
		replace   = !grow && (count_q != '0) && min_gt;
		new_count = grow ? (count_q + CNT_W'(1)) : count_q;
	end

	// Row of cells holding the kept values in descending order.
	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_val[i] = sample;
			assign left_gt[i]  = 1'b0;
		end else begin : g_body
			assign left_val[i] = cell_val[i-1];
			assign left_gt[i]  = gt_vec[i-1];
		end

		assign ctl[i].valid = (CNT_W'(i) < count_q);
		assign ctl[i].load  = s_acc && (grow || replace) && (CNT_W'(i) < new_count);

		ksel_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.sample    (sample),
			.left_value(left_val[i]),
			.left_gt   (left_gt[i]),
			.value     (cell_val[i]),
			.gt        (gt_vec[i])
		);
	end

	// Kept count; the last item of a set clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s_acc) begin
			count_q <= s_tlast ? '0 : new_count;
		end
	end

	// Remember where the smallest kept value sits after the last item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (s_acc && s_tlast) begin
			pend_s1 <= 1'b1;
		end else if (can_load) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && s_tlast) begin
			idx_s1   <= IDX_W'(new_count - CNT_W'(1));
			found_s1 <= (new_count >= k_eff);
		end
	end

	// Output register; reading the row before it is overwritten by the next set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pend_s1 && can_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1 && can_load) begin
			m_data_q  <= found_s1 ? cell_val[idx_s1] : '0;
			m_found_q <= found_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_data_q);
	assign m_tuser  = m_found_q;

	// Checks on the control logic.
	`KSEL_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(K_MAX))
	`KSEL_ASSERT_NEXT(a_clear_on_last, s_acc && s_tlast, count_q == '0)
	`KSEL_ASSERT_NEXT(a_count_holds, !s_acc, $stable(count_q))
	`KSEL_ASSERT_NEXT(a_result_loaded, pend_s1 && can_load, m_tvalid)
	`KSEL_ASSERT_ALWAYS(a_not_found_zero, !(m_tvalid && !m_tuser) || (m_tdata == '0))

endmodule

// File: src/ksel_cell.sv
module ksel_cell
	import ksel_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  cell_ctl_t                    ctl,
	input  logic signed [DATA_WIDTH-1:0] sample,
	input  logic signed [DATA_WIDTH-1:0] left_value,
	input  logic                         left_gt,
	output logic signed [DATA_WIDTH-1:0] value,
	output logic                         gt
);

	logic signed [DATA_WIDTH-1:0] value_q;

	// The new sample belongs at or before this cell when the cell is empty
	// or the sample is strictly greater than its value.
	assign gt    = !ctl.valid || (sample > value_q);
	assign value = value_q;

	// Shift from the left neighbor when the sample lands further left,
	// take the sample when it lands here, otherwise hold.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (left_gt) begin
				value_q <= left_value;
			end else if (gt) begin
				value_q <= sample;
			end
		end
	end

endmodule

// File: tb/kth_largest_stream_select_tb.sv
`timescale 1ns / 100ps

// One expected result item: the k-th largest value of a set and its found flag.
typedef struct packed {
	logic [31:0] kth_value;
	logic        found;
} kth_result_t;

// Tracks the top-k list of the set in progress and queues the result item
// that each set end should produce.
class kth_scoreboard;
	logic signed [31:0] top_values[16];
	int unsigned        top_count;
	logic [4:0]         rank_reg;
	kth_result_t        expected_results[$];
	int unsigned        errors;

	function new();
		top_count = 0;
		rank_reg  = 5'd1;
		errors    = 0;
		foreach (top_values[i]) top_values[i] = '0;
	endfunction

	function void set_rank(logic [4:0] value);
		rank_reg = value;
	endfunction

	// A rank of zero acts as one; ranks above the list depth saturate.
	function int unsigned eff_rank();
		if (rank_reg == 0) return 1;
		if (rank_reg > 16) return 16;
		return rank_reg;
	endfunction

	function int unsigned pending();
		return expected_results.size();
	endfunction

	// Position of the smallest kept value; only valid entries are scanned.
	function int unsigned smallest_pos();
		int unsigned best;
		best = 0;
		for (int unsigned i = 1; i < top_count; i++) begin
			if (top_values[i] < top_values[best]) best = i;
		end
		return best;
	endfunction

	// Called for every accepted input item.
	function void note_sample(logic signed [31:0] value, logic set_end);
		int unsigned k;
		int unsigned m;
		kth_result_t res;
		k = eff_rank();
		if (top_count < k) begin
			top_values[top_count] = value;
			top_count++;
		end else if (top_count > 0) begin
			m = smallest_pos();
			// An equal value never displaces the smallest kept one.
			if (top_values[m] < value) top_values[m] = value;
		end
		if (set_end) begin
			if (top_count >= k) begin
				res.kth_value = top_values[smallest_pos()];
				res.found     = 1'b1;
			end else begin
				res.kth_value = '0;
				res.found     = 1'b0;
			end
			expected_results.push_back(res);
			top_count = 0;
		end
	endfunction

	// Called for every accepted result item.
	function void check_result(logic [31:0] kth_value, logic found);
		kth_result_t exp_res;
		if (expected_results.size() == 0) begin
			$error("unexpected result item: kth_value %h found %b", kth_value, found);
			errors++;
			return;
		end
		exp_res = expected_results.pop_front();
		if (kth_value !== exp_res.kth_value) begin
			$error("kth_value: expected %h, actual %h", exp_res.kth_value, kth_value);
			errors++;
		end
		if (found !== exp_res.found) begin
			$error("found: expected %b, actual %b", exp_res.found, found);
			errors++;
		end
	endfunction
endclass

module kth_largest_stream_select_tb;
	import ksel_pkg::*;

	localparam int unsigned DW          = 32;
	localparam int unsigned ITEM_TARGET = 2000;
	localparam int unsigned SETTLE      = 4;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [RANK_W-1:0] cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [DW-1:0]     s_tdata;  // [31:0] sample_value
	logic              s_tlast;  // set_end
	logic              m_tvalid;
	logic              m_tready;
	logic [DW-1:0]     m_tdata;  // [31:0] kth_value
	logic              m_tuser;  // found

	kth_scoreboard sb;
	int unsigned   items_sent;
	int unsigned   cycle_count;
	int unsigned   hold_left;
	bit            steady_run;
	bit            hold_request;

	kth_largest_stream_select #(
		.K_MAX(16),
		.DATA_WIDTH(DW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[kth_largest_stream_select] ERROR");
			$finish;
		end
	end

	// Handshake monitor; results are checked before the same edge's input is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata[31:0], m_tuser);
			if (s_tvalid && s_tready) sb.note_sample(s_tdata[31:0], s_tlast);
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	initial begin
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= steady_run || ($urandom_range(99) >= 12);
			end
		end
	end

	// Values lean toward the extremes and a narrow band that produces ties.
	function automatic logic [31:0] rand_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return 32'($urandom_range(7)) - 32'd4;
			default: return $urandom;
		endcase
	endfunction

	// Offer one input item and wait until it is taken.
	task automatic send_item(logic [31:0] value, logic set_end);
		while (!steady_run && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= set_end;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering items until every expected result item has come back.
	// The first edge lets the monitor note an item taken at the previous edge.
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Rank is only changed with the block idle.
	task automatic set_rank(logic [RANK_W-1:0] value);
		wait_results_done();
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_rank(value);
	endtask

	// A set of random values; the sender may pause mid-set at pause_at.
	task automatic send_set(int unsigned len, int pause_at);
		for (int unsigned i = 0; i < len; i++) begin
			if (int'(i) == pause_at) wait_results_done();
			send_item(rand_value(), i == len - 1);
		end
	endtask

	initial begin
		int unsigned phase;
		int unsigned phase_items;
		int unsigned k;
		int unsigned len;
		int          pause_at;
		logic [RANK_W-1:0] rank;

		sb           = new();
		items_sent   = 0;
		steady_run   = 1'b0;
		hold_request = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting at the reset rank of one.
		send_item(32'h8000_0000, 1'b1);
		send_item(32'h7fff_ffff, 1'b1);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h7fff_ffff, 1'b0);
		send_item(32'hffff_ffff, 1'b0);
		send_item(32'h0000_0000, 1'b1);

		// Ties and a set shorter than the rank.
		set_rank(5'd3);
		send_item(32'd5, 1'b0);
		send_item(32'd5, 1'b0);
		send_item(32'd5, 1'b0);
		send_item(32'd5, 1'b1);
		send_item(32'd1, 1'b0);
		send_item(32'd2, 1'b1);
		send_item(32'hffff_ffff, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h7fff_ffff, 1'b0);
		send_item(32'd7, 1'b0);
		send_item(32'd7, 1'b0);
		send_item(32'd8, 1'b1);

		// A rank of zero behaves as one.
		set_rank(5'd0);
		send_item(32'd3, 1'b0);
		send_item(32'hffff_fffd, 1'b1);

		// A rank past the list depth saturates, so five values are too few.
		set_rank(5'd31);
		for (int unsigned i = 0; i < 5; i++) send_item(rand_value(), i == 4);

		// Random phases, each with its own rank.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: rank = 5'd16;
				1: rank = 5'd2;
				2: rank = 5'd31;
				3: rank = 5'd1;
				4: rank = 5'd0;
				5: rank = 5'd8;
				default: rank = RANK_W'($urandom_range(31));
			endcase
			set_rank(rank);
			k = sb.eff_rank();
			steady_run = (phase == 1);
			// Output held off while short sets keep coming, so the block fills up.
			if (phase == 3) hold_request = 1'b1;
			phase_items = 0;
			while (phase_items < 150) begin
				if (phase == 3) len = $urandom_range(1, 2);
				else if ($urandom_range(9) == 0) len = $urandom_range(1, k);
				else len = $urandom_range(1, 2 * k + 4);
				pause_at = (phase == 5 && phase_items == 0) ? int'(len / 2) : -1;
				send_set(len, pause_at);
				phase_items += len;
			end
			steady_run = 1'b0;
			phase++;
		end

		// Drain and let the pipeline settle.
		wait_results_done();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[kth_largest_stream_select] OK");
		end else begin
			$display("[kth_largest_stream_select] ERROR");
		end
		$finish;
	end

endmodule
